[sv/tat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types, opcodes and constants of the triangle affine transform.
// ----------------------------------------------------------------------------
`default_nettype none

package tat_pkg;

    localparam logic [1:0] OP_TRANS = 2'd0;
    localparam logic [1:0] OP_SCALE = 2'd1;
    localparam logic [1:0] OP_ROT   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam int unsigned TURN_UNITS = 23040;
    localparam int unsigned QUAD_UNITS = 5760;

    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;

    localparam int NUM_REGS = 6;

    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_AY = 3'd1;
    localparam logic [2:0] REG_BX = 3'd2;
    localparam logic [2:0] REG_BY = 3'd3;
    localparam logic [2:0] REG_CX = 3'd4;
    localparam logic [2:0] REG_CY = 3'd5;

    localparam logic [15:0] RST_AX = 16'd150;
    localparam logic [15:0] RST_AY = 16'd50;
    localparam logic [15:0] RST_BX = 16'd100;
    localparam logic [15:0] RST_BY = 16'd100;
    localparam logic [15:0] RST_CX = 16'd200;
    localparam logic [15:0] RST_CY = 16'd100;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [1:0]         quad;
        logic               rzero;
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_trig;

    // arctangent in 2^-24 degree
    function automatic logic [29:0] f_atan(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'd754974720;
            5'd1:  r = 30'd445687602;
            5'd2:  r = 30'd235489088;
            5'd3:  r = 30'd119537938;
            5'd4:  r = 30'd60000934;
            5'd5:  r = 30'd30029717;
            5'd6:  r = 30'd15018523;
            5'd7:  r = 30'd7509720;
            5'd8:  r = 30'd3754917;
            5'd9:  r = 30'd1877466;
            5'd10: r = 30'd938734;
            5'd11: r = 30'd469367;
            5'd12: r = 30'd234684;
            5'd13: r = 30'd117342;
            5'd14: r = 30'd58671;
            5'd15: r = 30'd29335;
            5'd16: r = 30'd14668;
            5'd17: r = 30'd7334;
            5'd18: r = 30'd3667;
            5'd19: r = 30'd1833;
            5'd20: r = 30'd917;
            5'd21: r = 30'd458;
            5'd22: r = 30'd229;
            5'd23: r = 30'd115;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/tat_angle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_angle
// Two stages: angle modulo one turn, then quadrant and remainder split.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_angle import tat_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [15:0] i_ox,
    input  wire logic signed [15:0] i_oy,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_cmd                    o_cmd,
    output logic [12:0]             o_rem
);

    logic        r_va, r_vb;
    t_cmd        r_cmd_a, r_cmd_b;
    logic [14:0] r_m;
    logic [12:0] r_rem;
    logic        en_a, en_b;
    logic signed [17:0] s_t;
    logic [16:0] t;
    logic [16:0] n_m;
    logic [14:0] m_q;
    logic [1:0]  n_quad;
    t_cmd        n_cmd_a, n_cmd_b;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    assign s_t = 18'(i_ox) + 18'sd46080;
    assign t   = s_t[16:0];

    always_comb begin
        if (t >= 17'(3 * TURN_UNITS)) begin
            n_m = t - 17'(3 * TURN_UNITS);
        end else if (t >= 17'(2 * TURN_UNITS)) begin
            n_m = t - 17'(2 * TURN_UNITS);
        end else if (t >= 17'(TURN_UNITS)) begin
            n_m = t - 17'(TURN_UNITS);
        end else begin
            n_m = t;
        end
    end

    always_comb begin
        if (r_m >= 15'(3 * QUAD_UNITS)) begin
            n_quad = 2'd3;
            m_q    = r_m - 15'(3 * QUAD_UNITS);
        end else if (r_m >= 15'(2 * QUAD_UNITS)) begin
            n_quad = 2'd2;
            m_q    = r_m - 15'(2 * QUAD_UNITS);
        end else if (r_m >= 15'(QUAD_UNITS)) begin
            n_quad = 2'd1;
            m_q    = r_m - 15'(QUAD_UNITS);
        end else begin
            n_quad = 2'd0;
            m_q    = r_m;
        end
    end

    always_comb begin
        n_cmd_a       = '0;
        n_cmd_a.op    = i_op;
        n_cmd_a.ox    = i_ox;
        n_cmd_a.oy    = i_oy;
        n_cmd_b       = r_cmd_a;
        n_cmd_b.quad  = n_quad;
        n_cmd_b.rzero = (m_q == 15'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid && (i_op != OP_NONE);
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_cmd_a <= n_cmd_a;
            r_m     <= n_m[14:0];
        end
        if (en_b) begin
            r_cmd_b <= n_cmd_b;
            r_rem   <= m_q[12:0];
        end
    end

    assign o_valid = r_vb;
    assign o_cmd   = r_cmd_b;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

[sv/tat_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_cordic
// Rotation-mode CORDIC, one iteration per stage, then quadrant fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_cordic import tat_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  t_cmd             i_cmd,
    input  wire logic [12:0] i_rem,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_trig            o_trig
);

    logic               r_v   [STEPS];
    t_cmd               r_cmd [STEPS];
    logic signed [31:0] r_x   [STEPS];
    logic signed [31:0] r_y   [STEPS];
    logic signed [32:0] r_z   [STEPS];
    logic               en    [STEPS+1];

    logic               r_vq;
    t_trig              r_trig;
    t_trig              n_trig;
    logic signed [31:0] cc, ss;

    assign o_ready = en[0];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic               v_in;
        t_cmd               c_in;
        logic signed [31:0] x_in, y_in, dx, dy;
        logic signed [32:0] z_in, at;

        if (i == 0) begin : g_first
            assign v_in = i_valid;
            assign c_in = i_cmd;
            assign x_in = CORDIC_X0;
            assign y_in = '0;
            assign z_in = $signed({2'b00, i_rem, 18'd0});
        end else begin : g_next
            assign v_in = r_v[i-1];
            assign c_in = r_cmd[i-1];
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        assign en[i] = !r_v[i] || en[i+1];
        assign dx    = y_in >>> i;
        assign dy    = x_in >>> i;
        assign at    = $signed({3'b000, f_atan(5'(i))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (en[i]) begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[i]) begin
                r_cmd[i] <= c_in;
                if (!z_in[32]) begin
                    r_x[i] <= x_in - dx;
                    r_y[i] <= y_in + dy;
                    r_z[i] <= z_in - at;
                end else begin
                    r_x[i] <= x_in + dx;
                    r_y[i] <= y_in - dy;
                    r_z[i] <= z_in + at;
                end
            end
        end
    end

    assign en[STEPS] = !r_vq || i_ready;

    assign cc = r_cmd[STEPS-1].rzero ? ONE_Q30 : r_x[STEPS-1];
    assign ss = r_cmd[STEPS-1].rzero ? '0 : r_y[STEPS-1];

    always_comb begin
        n_trig.cmd = r_cmd[STEPS-1];
        case (r_cmd[STEPS-1].quad)
            2'd1: begin
                n_trig.c = -ss;
                n_trig.s = cc;
            end
            2'd2: begin
                n_trig.c = -cc;
                n_trig.s = -ss;
            end
            2'd3: begin
                n_trig.c = ss;
                n_trig.s = -cc;
            end
            default: begin
                n_trig.c = cc;
                n_trig.s = ss;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (en[STEPS]) begin
            r_vq <= r_v[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[STEPS]) begin
            r_trig <= n_trig;
        end
    end

    assign o_valid = r_vq;
    assign o_trig  = r_trig;

endmodule

`default_nettype wire

[sv/tat_vertex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_vertex
// Issues the three vertices of a command, multiplies, sums, truncates and
// saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_vertex import tat_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [5:0][15:0] i_vert,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  t_trig                 i_trig,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic signed [15:0]    o_px,
    output logic signed [15:0]    o_py,
    output logic [1:0]            o_idx,
    output logic                  o_last
);

    function automatic logic signed [15:0] f_fix(input logic [1:0] op,
                                                input logic signed [48:0] v);
        logic signed [48:0] b;
        logic signed [48:0] q;
        b = v;
        if (op == OP_ROT) begin
            if (v[48]) begin
                b = v + 49'sd1073741823;
            end
            q = b >>> 30;
        end else if (op == OP_SCALE) begin
            if (v[48]) begin
                b = v + 49'sd255;
            end
            q = b >>> 8;
        end else begin
            q = v;
        end
        if (q > 49'sd32767) begin
            q = 49'sd32767;
        end else if (q < -49'sd32768) begin
            q = -49'sd32768;
        end
        return q[15:0];
    endfunction

    logic               r_sv;
    t_trig              r_trig;
    logic [1:0]         r_cnt;
    logic               en_m, en_a, en_t;
    logic signed [15:0] vx, vy;
    logic signed [31:0] mcx, mcy;

    logic               r_vm, r_va, r_vt;
    logic [1:0]         r_op_m, r_op_a;
    logic [1:0]         r_idx_m, r_idx_a, r_idx_t;
    logic signed [47:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [16:0] r_tx, r_ty;
    logic signed [48:0] r_sx, r_sy;
    logic signed [15:0] r_px, r_py;
    logic signed [47:0] n_p0, n_p1, n_p2, n_p3;
    logic signed [48:0] n_sx, n_sy;

    assign en_t    = !r_vt || i_ready;
    assign en_a    = !r_va || en_t;
    assign en_m    = !r_vm || en_a;
    assign o_ready = !r_sv || (en_m && (r_cnt == 2'd2));

    always_comb begin
        case (r_cnt)
            2'd1: begin
                vx = i_vert[REG_BX];
                vy = i_vert[REG_BY];
            end
            2'd2: begin
                vx = i_vert[REG_CX];
                vy = i_vert[REG_CY];
            end
            default: begin
                vx = i_vert[REG_AX];
                vy = i_vert[REG_AY];
            end
        endcase
    end

    assign mcx  = (r_trig.cmd.op == OP_ROT) ? r_trig.c : 32'(r_trig.cmd.ox);
    assign mcy  = (r_trig.cmd.op == OP_ROT) ? r_trig.c : 32'(r_trig.cmd.oy);
    assign n_p0 = vx * mcx;
    assign n_p1 = vy * r_trig.s;
    assign n_p2 = vx * r_trig.s;
    assign n_p3 = vy * mcy;

    always_comb begin
        case (r_op_m)
            OP_ROT: begin
                n_sx = 49'(r_p0) - 49'(r_p1);
                n_sy = 49'(r_p2) + 49'(r_p3);
            end
            OP_SCALE: begin
                n_sx = 49'(r_p0);
                n_sy = 49'(r_p3);
            end
            default: begin
                n_sx = 49'(r_tx);
                n_sy = 49'(r_ty);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= 2'd0;
            r_vm  <= 1'b0;
            r_va  <= 1'b0;
            r_vt  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_sv  <= i_valid;
                r_cnt <= 2'd0;
            end else if (en_m) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (en_m) begin
                r_vm <= r_sv;
            end
            if (en_a) begin
                r_va <= r_vm;
            end
            if (en_t) begin
                r_vt <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_trig <= i_trig;
        end
        if (en_m) begin
            r_op_m  <= r_trig.cmd.op;
            r_idx_m <= r_cnt;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_tx    <= 17'(vx) + 17'(r_trig.cmd.ox);
            r_ty    <= 17'(vy) + 17'(r_trig.cmd.oy);
        end
        if (en_a) begin
            r_op_a  <= r_op_m;
            r_idx_a <= r_idx_m;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
        end
        if (en_t) begin
            r_idx_t <= r_idx_a;
            r_px    <= f_fix(r_op_a, r_sx);
            r_py    <= f_fix(r_op_a, r_sy);
        end
    end

    assign o_valid = r_vt;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_idx   = r_idx_t;
    assign o_last  = (r_idx_t == 2'd2);

endmodule

`default_nettype wire

[sv/triangle_affine_transform_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_affine_transform_top
// Translate, scale or rotate a stored triangle, three vertex results per
// command.
// ----------------------------------------------------------------------------
// A command takes three transfers of the output port, one per vertex; the
// vertex issue stage takes a new command only as it issues the last vertex of
// the one before, and so sets the command rate. A command passes two angle
// stages, one stage per CORDIC iteration, a quadrant stage, vertex issue,
// multiply, sum and truncate/saturate. Vertex registers are written through
// the config port; the user must write them only while no command is in
// flight, which the block does not enforce. Opcode 3 produces no results.
`default_nettype none

module triangle_affine_transform_top import tat_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [15:0] i_operand_x,
    input  wire logic signed [15:0] i_operand_y,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_point_x,
    output logic signed [15:0]      o_point_y,
    output logic [1:0]              o_vertex_index,
    output logic                    o_last_vertex,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    logic [5:0][15:0] r_vert;
    logic             ang_valid, ang_ready;
    t_cmd             ang_cmd;
    logic [12:0]      ang_rem;
    logic             trig_valid, trig_ready;
    t_trig            trig;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert[REG_AX] <= RST_AX;
            r_vert[REG_AY] <= RST_AY;
            r_vert[REG_BX] <= RST_BX;
            r_vert[REG_BY] <= RST_BY;
            r_vert[REG_CX] <= RST_CX;
            r_vert[REG_CY] <= RST_CY;
        end else if (i_cfg_valid && (i_cfg_index < 3'(NUM_REGS))) begin
            r_vert[i_cfg_index] <= i_cfg_data;
        end
    end

    tat_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_opcode),
        .i_ox    (i_operand_x),
        .i_oy    (i_operand_y),
        .o_valid (ang_valid),
        .i_ready (ang_ready),
        .o_cmd   (ang_cmd),
        .o_rem   (ang_rem)
    );

    tat_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ang_valid),
        .o_ready (ang_ready),
        .i_cmd   (ang_cmd),
        .i_rem   (ang_rem),
        .o_valid (trig_valid),
        .i_ready (trig_ready),
        .o_trig  (trig)
    );

    tat_vertex u_vertex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vert  (r_vert),
        .i_valid (trig_valid),
        .o_ready (trig_ready),
        .i_trig  (trig),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_px    (o_point_x),
        .o_py    (o_point_y),
        .o_idx   (o_vertex_index),
        .o_last  (o_last_vertex)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_vertex == (o_vertex_index == 2'd2)))
        else $error("last flag does not match vertex index");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vertex_index != 2'd3))
        else $error("vertex index out of range");

endmodule

`default_nettype wire

[test/triangle_affine_transform_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_affine_transform_top_test
// Drives translate, scale and rotate commands and vertex register writes into
// the triangle transform, predicts each vertex result with a bit-exact CORDIC
// and fixed-point model, and checks every output transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_affine_transform_top_test;
    import tat_pkg::*;

    localparam int LATENCY   = CORDIC_STEPS_DEF + 7;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 200;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } t_item;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [1:0]         idx;
        logic               last;
    } t_vertex;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         in_op = '0;
    logic signed [15:0] in_ox = '0;
    logic signed [15:0] in_oy = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_px;
    logic signed [15:0] out_py;
    logic [1:0]         out_idx;
    logic               out_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    t_item      pending_cmds[$];
    t_vertex    expected_vertices[$];
    logic [15:0] triangle[NUM_REGS];
    int         errors = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    int         burst_left = 0;
    int         hold_off = 0;
    bit         hold_done = 1'b0;

    triangle_affine_transform_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(in_op), .i_operand_x(in_ox), .i_operand_y(in_oy),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_point_x(out_px), .o_point_y(out_py),
        .o_vertex_index(out_idx), .o_last_vertex(out_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint arith_shr(longint v, int sh);
        if (v < 0) return -1 - ((-1 - v) >>> sh);
        return v >>> sh;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115};
        return tbl[i];
    endfunction

    task automatic rotation_terms(input longint angle, output longint cv,
                                  output longint sv);
        longint m, quad, rem, x, y, z, dx, dy, t;
        m = angle % 23040;
        if (m < 0) m += 23040;
        quad = m / 5760;
        rem = m % 5760;
        if (rem == 0) begin
            cv = 64'sd1 <<< 30;
            sv = 0;
        end else begin
            x = 652032874;
            y = 0;
            z = rem <<< 18;
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
                dx = arith_shr(y, i);
                dy = arith_shr(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_entry(i);
                end else begin
                    x += dx; y -= dy; z += atan_entry(i);
                end
            end
            cv = x;
            sv = y;
        end
        case (quad)
            1: begin t = cv; cv = -sv; sv = t; end
            2: begin cv = -cv; sv = -sv; end
            3: begin t = cv; cv = sv; sv = -t; end
            default: ;
        endcase
    endtask

    task automatic predict_transform(input t_item it);
        longint cv, sv, vx, vy, px, py;
        t_vertex v;
        cv = 0;
        sv = 0;
        if (it.op == OP_NONE) return;
        if (it.op == OP_ROT) rotation_terms(longint'(it.ox), cv, sv);
        for (int k = 0; k < 3; k++) begin
            vx = longint'($signed(triangle[2 * k]));
            vy = longint'($signed(triangle[2 * k + 1]));
            if (it.op == OP_TRANS) begin
                px = vx + it.ox;
                py = vy + it.oy;
            end else if (it.op == OP_SCALE) begin
                px = (vx * it.ox) / 256;
                py = (vy * it.oy) / 256;
            end else begin
                px = (vx * cv - vy * sv) / (64'sd1 <<< 30);
                py = (vx * sv + vy * cv) / (64'sd1 <<< 30);
            end
            v.px = clamp16(px);
            v.py = clamp16(py);
            v.idx = k[1:0];
            v.last = (k == 2);
            expected_vertices.push_back(v);
        end
    endtask

    // driver
    always @(posedge clk) begin
        t_item it;
        if (in_valid && in_ready) begin
            predict_transform(pending_cmds.pop_front());
        end
        if (!(in_valid && !in_ready)) begin
            if (rst_n && pending_cmds.size() > 0 && !(in_valid && in_ready
                    && pending_cmds.size() == 0) && gap_left == 0) begin
                it = pending_cmds[0];
                in_valid <= 1'b1;
                in_op <= it.op;
                in_ox <= it.ox;
                in_oy <= it.oy;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_vertex e;
        cycle_count++;
        if (out_valid && out_ready) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected vertex transfer");
                errors++;
            end else begin
                e = expected_vertices.pop_front();
                if (out_px !== e.px) begin
                    $error("point_x expected %0d got %0d", e.px, out_px); errors++;
                end
                if (out_py !== e.py) begin
                    $error("point_y expected %0d got %0d", e.py, out_py); errors++;
                end
                if (out_idx !== e.idx) begin
                    $error("vertex_index expected %0d got %0d", e.idx, out_idx); errors++;
                end
                if (out_last !== e.last) begin
                    $error("last_vertex expected %0d got %0d", e.last, out_last);
                    errors++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off--;
            out_ready <= 1'b0;
        end else if (!hold_done && rst_n && expected_vertices.size() > 20) begin
            hold_done = 1'b1;
            hold_off = 150;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
        if (cycle_count > MAX_CYC) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS) triangle[idx] = val;
    endtask

    task automatic drain;
        while (pending_cmds.size() > 0 || in_valid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'(-32768 + $urandom_range(0, 3));
            1: return 16'(32767 - $urandom_range(0, 3));
            2: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item rand_cmd();
        t_item it;
        it.op = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
        it.ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                16'($signed($urandom_range(0, 1024)) - 512);
        it.oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                16'($signed($urandom_range(0, 1024)) - 512);
        if (it.op == OP_ROT && $urandom_range(0, 4) == 0)
            it.ox = 16'(5760 * $signed($urandom_range(0, 10)) - 28800);
        return it;
    endfunction

    initial begin
        triangle = '{RST_AX, RST_AY, RST_BX, RST_BY, RST_CX, RST_CY};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset triangle, all operations, extremes, right angles
        pending_cmds.push_back('{OP_TRANS, 16'sd0, 16'sd0});
        pending_cmds.push_back('{OP_TRANS, 16'sh7fff, 16'sh8000});
        pending_cmds.push_back('{OP_TRANS, 16'sh8000, 16'sh7fff});
        pending_cmds.push_back('{OP_SCALE, 16'sd256, 16'sd256});
        pending_cmds.push_back('{OP_SCALE, 16'sh7fff, 16'sh8000});
        pending_cmds.push_back('{OP_SCALE, -16'sd1, 16'sd1});
        pending_cmds.push_back('{OP_ROT, 16'sd0, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sd5760, 16'sh7fff});
        pending_cmds.push_back('{OP_ROT, 16'sd11520, 16'sd0});
        pending_cmds.push_back('{OP_ROT, -16'sd5760, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sd2880, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sh7fff, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sh8000, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sd1, 16'sd0});
        pending_cmds.push_back('{OP_NONE, 16'sh7fff, 16'sh8000});
        pending_cmds.push_back('{OP_TRANS, 16'sd1, -16'sd1});
        drain();
        // extreme triangle, including out-of-range register index
        write_reg(REG_AX, 16'h7fff);
        write_reg(REG_AY, 16'h8000);
        write_reg(REG_BX, 16'h8000);
        write_reg(REG_BY, 16'h7fff);
        write_reg(REG_CX, 16'h0000);
        write_reg(REG_CY, 16'hffff);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'h5678);
        pending_cmds.push_back('{OP_SCALE, 16'sh7fff, 16'sh7fff});
        pending_cmds.push_back('{OP_SCALE, 16'sh8000, 16'sh8000});
        pending_cmds.push_back('{OP_ROT, 16'sd2880, 16'sd0});
        pending_cmds.push_back('{OP_ROT, 16'sd17280, 16'sd0});
        pending_cmds.push_back('{OP_TRANS, 16'sh7fff, 16'sh8000});
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            for (int r = 0; r < NUM_REGS; r++) write_reg(r[2:0], rand_coord());
            for (int n = 0; n < N_RANDOM / 4; n++) pending_cmds.push_back(rand_cmd());
            drain();
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/tat_pkg.sv
sv/tat_angle.sv
sv/tat_cordic.sv
sv/tat_vertex.sv
sv/triangle_affine_transform_top.sv
test/triangle_affine_transform_top_test.sv
